FILE: src/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the stack pattern deleter.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

	// field widths
	localparam int FUNC_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int IDX_W      = 12;
	localparam int COUNT_W    = 13;
	localparam int PROG_W     = 6;
	localparam int CFG_DATA_W = 64;
	localparam int REG_IDX_W  = 3;

	// pattern storage
	localparam int PAT_BYTES     = 32;
	localparam int PAT_SEL_W     = 5;
	localparam int BYTES_PER_REG = 8;
	localparam int PAT_REGS      = 4;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_PAT_LEN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAT_0   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PAT_1   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PAT_2   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PAT_3   = 3'd4;

	typedef struct packed {
		logic [PROG_W-1:0]                len;
		logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;
	} spd_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] text;
		logic [PROG_W-1:0] prog;
	} spd_entry_t;

endpackage

`default_nettype wire

FILE: src/spd_req_if.sv
// ----------------------------------------------------------------------------
// spd_req_if
// Input word channel: function code, text byte and read position.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_req_if;
	logic                            valid;
	logic                            ready;
	logic [spd_pkg::FUNC_W-1:0]      func;
	logic [spd_pkg::BYTE_W-1:0]      text_byte;
	logic [spd_pkg::IDX_W-1:0]       read_index;

	modport source (output valid, func, text_byte, read_index, input ready);
	modport sink   (input valid, func, text_byte, read_index, output ready);
endinterface

`default_nettype wire

FILE: src/spd_rsp_if.sv
// ----------------------------------------------------------------------------
// spd_rsp_if
// Result word channel: stack count, read data and push status.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [spd_pkg::COUNT_W-1:0]     kept_count;
	logic [spd_pkg::BYTE_W-1:0]      read_byte;
	logic                            read_valid;
	logic                            deleted;
	logic                            overflow;

	modport source (output valid, kept_count, read_byte, read_valid, deleted, overflow,
		input ready);
	modport sink   (input valid, kept_count, read_byte, read_valid, deleted, overflow,
		output ready);
endinterface

`default_nettype wire

FILE: src/spd_cfg.sv
// ----------------------------------------------------------------------------
// spd_cfg
// Pattern length and pattern byte registers; length is clamped on write.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_cfg #(
	parameter int MAX_PATTERN = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [spd_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [spd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output spd_pkg::spd_cfg_t                      cfg
);

	localparam logic [spd_pkg::PROG_W-1:0] MAX_LEN = spd_pkg::PROG_W'(MAX_PATTERN);

	logic [spd_pkg::PROG_W-1:0]     len_q;
	logic [spd_pkg::CFG_DATA_W-1:0] pat_q [spd_pkg::PAT_REGS];
	logic [spd_pkg::PROG_W-1:0]     len_wr;

	always_comb begin
		len_wr = cfg_wdata[spd_pkg::PROG_W-1:0];
		if (len_wr == '0) begin
			len_wr = spd_pkg::PROG_W'(1);
		end else if (len_wr > MAX_LEN) begin
			len_wr = MAX_LEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= spd_pkg::PROG_W'(1);
			for (int i = 0; i < spd_pkg::PAT_REGS; i++) begin
				pat_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				spd_pkg::REG_PAT_LEN: len_q    <= len_wr;
				spd_pkg::REG_PAT_0:   pat_q[0] <= cfg_wdata;
				spd_pkg::REG_PAT_1:   pat_q[1] <= cfg_wdata;
				spd_pkg::REG_PAT_2:   pat_q[2] <= cfg_wdata;
				spd_pkg::REG_PAT_3:   pat_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.len = len_q;
		for (int i = 0; i < spd_pkg::PAT_BYTES; i++) begin
			cfg.pat[i] = pat_q[i / spd_pkg::BYTES_PER_REG]
				[(i % spd_pkg::BYTES_PER_REG) * spd_pkg::BYTE_W +: spd_pkg::BYTE_W];
		end
	end

endmodule

`default_nettype wire

FILE: src/spd_stack_mem.sv
// ----------------------------------------------------------------------------
// spd_stack_mem
// Stack storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_stack_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int W     = 14
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/stack_pattern_deleter.sv
// ----------------------------------------------------------------------------
// stack_pattern_deleter
// Streaming pattern removal over a byte stack with per-entry match progress.
// ----------------------------------------------------------------------------
// pipeline: stage 1, then the output word register; throughput: one word
//   per cycle while rsp is not stalled; a push that deletes the pattern and
//   leaves the stack non-empty holds off the next word while the new top's
//   progress is refetched through the stack memory's registered read port
// reset: stack count, top progress and pattern bytes clear at once, length
//   resets to one; stack memory is not cleared and needs no clearing pass
`default_nettype none

module stack_pattern_deleter #(
	parameter int STACK_DEPTH = 4096,
	parameter int MAX_PATTERN = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [spd_pkg::REG_IDX_W-1:0]     cfg_index,
	input  wire logic [spd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	spd_req_if.sink                                req,
	spd_rsp_if.source                              rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int CW = (DW > spd_pkg::IDX_W) ? DW : spd_pkg::IDX_W;
	localparam int EW = $bits(spd_pkg::spd_entry_t);
	localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

	spd_pkg::spd_cfg_t   cfg;
	spd_pkg::spd_entry_t wr_entry;
	spd_pkg::spd_entry_t rd_entry;
	logic [EW-1:0]       rd_raw;

	logic [DW-1:0]               depth_q;
	logic [spd_pkg::PROG_W-1:0]  top_prog_q;

	logic                        s1_valid_q;
	logic                        s1_fetch_q;
	logic                        s1_rvalid_q;
	logic                        s1_del_q;
	logic                        s1_ovf_q;
	logic [DW-1:0]               s1_count_q;

	logic                        out_valid_q;
	logic [spd_pkg::COUNT_W-1:0] out_count_q;
	logic [spd_pkg::BYTE_W-1:0]  out_byte_q;
	logic                        out_rvalid_q;
	logic                        out_del_q;
	logic                        out_ovf_q;

	logic                        acc;
	logic                        s1_adv;
	logic                        is_push;
	logic                        is_read;
	logic                        is_clear;
	logic                        full;
	logic                        ext_hit;
	logic [spd_pkg::PROG_W-1:0]  prog_new;
	logic [DW-1:0]               depth_inc;
	logic [DW-1:0]               depth_pop;
	logic                        do_write;
	logic                        do_del;
	logic                        do_fetch;
	logic                        rd_ok;
	logic [DW-1:0]               depth_nxt;
	logic [AW-1:0]               rd_addr;

	spd_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	spd_stack_mem #(
		.DEPTH(STACK_DEPTH),
		.AW   (AW),
		.W    (EW)
	) u_mem (
		.clk   (clk),
		.we    (do_write),
		.waddr (depth_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (acc),
		.raddr (rd_addr),
		.rdata (rd_raw)
	);

	assign rd_entry = rd_raw;

	// handshake; a pending progress refetch holds off the next word
	assign s1_adv    = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = (!s1_valid_q || s1_adv) && !(s1_valid_q && s1_fetch_q);
	assign acc       = req.valid && req.ready;

	always_comb begin
		is_push  = (req.func == spd_pkg::FUNC_PUSH);
		is_read  = (req.func == spd_pkg::FUNC_READ);
		is_clear = (req.func == spd_pkg::FUNC_CLEAR);
		full     = (depth_q == FULL_DEPTH);

		// match progress of the pushed byte
		ext_hit = (top_prog_q < cfg.len) &&
			(req.text_byte == cfg.pat[top_prog_q[spd_pkg::PAT_SEL_W-1:0]]);
		if (ext_hit) begin
			prog_new = top_prog_q + spd_pkg::PROG_W'(1);
		end else if (req.text_byte == cfg.pat[0]) begin
			prog_new = spd_pkg::PROG_W'(1);
		end else begin
			prog_new = '0;
		end

		depth_inc = depth_q + DW'(1);
		depth_pop = (depth_inc > DW'(cfg.len)) ? (depth_inc - DW'(cfg.len)) : '0;

		do_write = acc && is_push && !full;
		do_del   = is_push && !full && (prog_new >= cfg.len);
		do_fetch = do_del && (depth_pop != '0);
		rd_ok    = is_read && (CW'(req.read_index) < CW'(depth_q));

		wr_entry.text = req.text_byte;
		wr_entry.prog = prog_new;

		if (is_push && !full) begin
			depth_nxt = do_del ? depth_pop : depth_inc;
		end else if (is_clear) begin
			depth_nxt = '0;
		end else begin
			depth_nxt = depth_q;
		end

		rd_addr = do_fetch ? AW'(depth_pop - DW'(1)) : AW'(req.read_index);
	end

	// stack count and top progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q    <= '0;
			top_prog_q <= '0;
		end else if (acc) begin
			depth_q <= depth_nxt;
			if (is_push && !full) begin
				top_prog_q <= do_del ? '0 : prog_new;
			end else if (is_clear) begin
				top_prog_q <= '0;
			end
		end else if (s1_valid_q && s1_fetch_q) begin
			top_prog_q <= rd_entry.prog;
		end
	end

	// stage 1: waits for the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_fetch_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
			s1_fetch_q <= do_fetch;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
			s1_fetch_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_rvalid_q <= rd_ok;
			s1_del_q    <= do_del;
			s1_ovf_q    <= is_push && full;
			s1_count_q  <= depth_nxt;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_count_q  <= spd_pkg::COUNT_W'(s1_count_q);
			out_byte_q   <= s1_rvalid_q ? rd_entry.text : '0;
			out_rvalid_q <= s1_rvalid_q;
			out_del_q    <= s1_del_q;
			out_ovf_q    <= s1_ovf_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.kept_count = out_count_q;
	assign rsp.read_byte  = out_byte_q;
	assign rsp.read_valid = out_rvalid_q;
	assign rsp.deleted    = out_del_q;
	assign rsp.overflow   = out_ovf_q;

	// checks
	a_fetch_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_fetch_q) |-> !req.ready)
		else $error("word accepted during progress refetch");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= FULL_DEPTH)
		else $error("stack count beyond stack depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> (depth_q < FULL_DEPTH))
		else $error("stack write while full");

	a_fetch_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && do_fetch) |=> (s1_valid_q && s1_fetch_q && depth_q < $past(depth_inc)))
		else $error("refetch without stack shrink");

endmodule

`default_nettype wire
